FILE: rtl/hgal_pkg.sv
// Shared types, codes and sizes of the generational handle allocator.
package hgal_pkg;

    // Table size and field widths
    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int GEN_W     = 8;
    localparam int ID_W      = 11;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int IN_W      = 24;
    localparam int OUT_W     = 40;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 2'd0,
        OP_DESTROY = 2'd1,
        OP_CHECK   = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_DEAD = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_STK,
        S_RD_GEN,
        S_EXEC
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic cap;      // latch input word
        logic rd_stk;   // read top of free stack
        logic rd_gen;   // read generation table
        logic exec;     // commit state and load result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // result register can take a word this cycle
    } t_sts;

endpackage

FILE: rtl/hgal_ctrl.sv
// Sequencing state machine of the handle allocator.
module hgal_ctrl import hgal_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_RD_STK;
            end
            S_RD_STK: n_state = S_RD_GEN;
            S_RD_GEN: n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.cap  = i_s_tvalid;
            end
            S_RD_STK: o_cmd.rd_stk = 1'b1;
            S_RD_GEN: o_cmd.rd_gen = 1'b1;
            S_EXEC:   o_cmd.exec   = i_sts.out_free;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/hgal_dp.sv
// Datapath of the handle allocator: tables, counters and result register.
module hgal_dp import hgal_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata,
    input  t_cmd             i_cmd,
    output t_sts             o_sts
);

    // Memories
    logic [GEN_W-1:0] r_gen_mem [MAX_SLOTS];
    logic [IDX_W-1:0] r_stk_mem [MAX_SLOTS];
    logic [GEN_W-1:0] r_gen_rd;
    logic [IDX_W-1:0] r_stk_rd;

    // Latched operation
    t_op              r_op;
    logic [ID_W-1:0]  r_id;
    logic [GEN_W-1:0] r_gen;

    // Counters
    logic [CNT_W-1:0] r_depth, n_depth;
    logic [CNT_W-1:0] r_ever,  n_ever;
    logic [CNT_W-1:0] r_live,  n_live;

    // Result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    // Exec signals
    logic [ID_W-1:0]   w_id_m1;
    logic [IDX_W-1:0]  w_idx;
    logic [CNT_W-1:0]  w_depth_m1;
    logic              w_alive;
    logic [IDX_W-1:0]  w_gen_addr;
    logic              w_gen_we;
    logic [IDX_W-1:0]  w_gen_waddr;
    logic [GEN_W-1:0]  w_gen_wdata;
    logic              w_stk_we;
    logic [ID_W-1:0]   w_res_id;
    logic [GEN_W-1:0]  w_res_gen;
    logic              w_res_alive;
    logic [STAT_W-1:0] w_res_stat;

    assign w_id_m1    = r_id - ID_W'(1);
    assign w_idx      = w_id_m1[IDX_W-1:0];
    assign w_depth_m1 = r_depth - CNT_W'(1);
    assign w_gen_addr = (r_op == OP_CREATE) ? r_stk_rd : w_idx;
    assign w_alive    = (r_id != '0) && (CNT_W'(r_id) <= r_ever) && (r_gen_rd == r_gen);

    assign o_sts.out_free = !r_out_valid || i_m_tready;

    // Input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_op  <= t_op'(i_s_tdata[OP_W-1:0]);
            r_id  <= i_s_tdata[OP_W +: ID_W];
            r_gen <= i_s_tdata[OP_W+ID_W +: GEN_W];
        end
    end

    // Free stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_stk) begin
            r_stk_rd <= r_stk_mem[w_depth_m1[IDX_W-1:0]];
        end
        if (w_stk_we) begin
            r_stk_mem[r_depth[IDX_W-1:0]] <= w_idx;
        end
    end

    // Generation table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_gen) begin
            r_gen_rd <= r_gen_mem[w_gen_addr];
        end
        if (w_gen_we) begin
            r_gen_mem[w_gen_waddr] <= w_gen_wdata;
        end
    end

    // Operation logic
    always_comb begin
        n_depth     = r_depth;
        n_ever      = r_ever;
        n_live      = r_live;
        w_gen_we    = 1'b0;
        w_gen_waddr = w_idx;
        w_gen_wdata = r_gen_rd + GEN_W'(1);
        w_stk_we    = 1'b0;
        w_res_id    = '0;
        w_res_gen   = '0;
        w_res_alive = 1'b0;
        w_res_stat  = ST_DONE;
        case (r_op)
            OP_CREATE: begin
                if (r_depth != '0) begin
                    // reuse most recently freed slot
                    n_depth   = w_depth_m1;
                    w_res_id  = ID_W'(r_stk_rd) + ID_W'(1);
                    w_res_gen = r_gen_rd;
                    n_live    = r_live + CNT_W'(1);
                end else if (r_ever < CNT_W'(MAX_SLOTS)) begin
                    // fresh slot, generation zero
                    w_gen_we    = i_cmd.exec;
                    w_gen_waddr = r_ever[IDX_W-1:0];
                    w_gen_wdata = '0;
                    n_ever      = r_ever + CNT_W'(1);
                    w_res_id    = ID_W'(r_ever) + ID_W'(1);
                    n_live      = r_live + CNT_W'(1);
                end else begin
                    w_res_stat = ST_FULL;
                end
            end
            OP_DESTROY: begin
                w_res_alive = w_alive;
                if (w_alive && (r_depth < CNT_W'(MAX_SLOTS))) begin
                    w_gen_we = i_cmd.exec;
                    w_stk_we = i_cmd.exec;
                    n_depth  = r_depth + CNT_W'(1);
                    if (r_live != '0) n_live = r_live - CNT_W'(1);
                end else begin
                    w_res_stat = ST_DEAD;
                end
            end
            OP_CHECK: begin
                w_res_alive = w_alive;
            end
            OP_CLEAR: begin
                n_depth = '0;
                n_ever  = '0;
                n_live  = '0;
            end
            default: begin
                w_res_stat = ST_DONE;
            end
        endcase
    end

    // Counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_ever  <= '0;
            r_live  <= '0;
        end else if (i_cmd.exec) begin
            r_depth <= n_depth;
            r_ever  <= n_ever;
            r_live  <= n_live;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register data
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= {(OUT_W-ID_W-GEN_W-1-STAT_W-CNT_W)'(0),
                           n_live[ID_W-1:0], w_res_stat, w_res_alive, w_res_gen, w_res_id};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: rtl/generational_handle_allocator_unit.sv
// Generational handle allocator: LIFO free-id stack with per-slot generations.
// Each word passes through stack read, generation read, then commit before its
// result is valid; no new word is taken until the last one has committed and
// the block is back in idle. The next word is taken while a result still waits
// in the output register and then holds in commit until that result is accepted.
// Reset (synchronous, active low) clears stack depth, high-water mark, live count
// and handshake state at once; the tables are not cleared.
module generational_handle_allocator_unit import hgal_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // [1:0] operation, [12:2] entity_id, [20:13] entity_generation, [23:21] zero
    input  logic [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // [10:0] handle_id, [18:11] handle_generation, [19] alive, [21:20] status,
    // [32:22] live_total, [39:33] zero
    output logic [OUT_W-1:0] o_m_tdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    hgal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hgal_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the generational handle allocator unit.
`timescale 1ns / 100ps

module testbench;
    import hgal_pkg::*;

    localparam int IDLE_LIMIT   = 4000;  // cycles without any handshake
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int RANDOM_ITEMS = 160;
    localparam int DRAIN_CYCLES = 16;

    // One result word's fields, packed in the reverse order of the block's layout
    typedef struct packed {
        logic [ID_W-1:0]   handle_id;
        logic [GEN_W-1:0]  handle_gen;
        logic              alive;
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   live_total;
    } t_alloc_result;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [GEN_W-1:0] gen;
    } t_handle;

    // Allocator predictor plus in-order result checker
    class handle_scoreboard;
        bit [GEN_W-1:0] gen_table [MAX_SLOTS];
        bit [IDX_W-1:0] free_ids [MAX_SLOTS];
        int             free_depth;
        int             high_water;
        int             live_handles;
        t_alloc_result  awaited[$];
        int             errors;

        function bit handle_live(int id, logic [GEN_W-1:0] gen);
            if (id == 0 || id > high_water || id > MAX_SLOTS)
                return 1'b0;
            return gen_table[id - 1] == gen;
        endfunction

        // Apply one accepted word to the shadow state, queue its result
        function t_alloc_result predict_op(t_op op, logic [ID_W-1:0] id,
                                           logic [GEN_W-1:0] gen);
            t_alloc_result r;
            int            slot;
            r = '0;
            r.status = ST_DONE;
            case (op)
                OP_CREATE: begin
                    if (free_depth > 0) begin
                        free_depth--;
                        slot = free_ids[free_depth];
                        r.handle_id  = ID_W'(slot + 1);
                        r.handle_gen = gen_table[slot];
                        live_handles++;
                    end else if (high_water < MAX_SLOTS) begin
                        gen_table[high_water] = '0;
                        high_water++;
                        r.handle_id = ID_W'(high_water);
                        live_handles++;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
                OP_DESTROY: begin
                    if (handle_live(id, gen)) begin
                        r.alive = 1'b1;
                        if (free_depth < MAX_SLOTS) begin
                            gen_table[id - 1] = gen_table[id - 1] + GEN_W'(1);
                            free_ids[free_depth] = IDX_W'(id - ID_W'(1));
                            free_depth++;
                            if (live_handles > 0)
                                live_handles--;
                        end else begin
                            // stack already full: stale handle is dropped
                            r.status = ST_DEAD;
                        end
                    end else begin
                        r.status = ST_DEAD;
                    end
                end
                OP_CHECK: begin
                    r.alive = handle_live(id, gen);
                end
                default: begin
                    free_depth   = 0;
                    high_water   = 0;
                    live_handles = 0;
                end
            endcase
            r.live_total = ID_W'(live_handles);
            awaited.insert(awaited.size(), r);
            return r;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] word);
            t_alloc_result want;
            if (awaited.size() == 0) begin
                $error("result word %h with no request outstanding", word);
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare_field("handle_id", want.handle_id, word[10:0]);
            compare_field("handle_generation", want.handle_gen, word[18:11]);
            compare_field("alive", want.alive, word[19]);
            compare_field("status", want.status, word[21:20]);
            compare_field("live_total", want.live_total, word[32:22]);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    // [1:0] operation, [12:2] entity_id, [20:13] entity_generation, [23:21] zero
    logic [IN_W-1:0]   i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    // [10:0] handle_id, [18:11] handle_generation, [19] alive, [21:20] status,
    // [32:22] live_total, [39:33] zero
    logic [OUT_W-1:0]  o_m_tdata;

    handle_scoreboard  sb;
    int                burst_left = 4;
    int                hold_requests = 0;
    int                holds_served = 0;
    int                hold_left = 0;
    int                stall_mode = 0;
    logic [31:0]       rx_cycle = '0;
    int                idle_cycles = 0;

    generational_handle_allocator_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Offer one word, wait for accept, then maybe end the burst
    task automatic send_item(input t_op op, input logic [ID_W-1:0] id,
                             input logic [GEN_W-1:0] gen, output t_alloc_result res);
        i_s_tdata  <= {{(IN_W - OP_W - ID_W - GEN_W){1'b0}}, gen, id, op};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        res = sb.predict_op(op, id, gen);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
        end
    endtask

    function automatic logic [ID_W-1:0] rand_id();
        return ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, MAX_SLOTS))
                                          : ID_W'($urandom_range(0, 8));
    endfunction

    function automatic logic [GEN_W-1:0] rand_gen();
        return ($urandom_range(0, 1) == 0) ? GEN_W'($urandom_range(0, 255))
                                          : GEN_W'($urandom_range(0, 3));
    endfunction

    // Result side: check accepted words, drive tready on its own pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready)
                sb.check_result(o_m_tdata);
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 50 == 0)
                stall_mode <= $urandom_range(0, 3);
            if (hold_left != 0) begin
                hold_left  <= hold_left - 1;
                i_m_tready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served <= hold_requests;
                hold_left    <= HOLD_CYCLES;
                i_m_tready   <= 1'b0;
            end else begin
                case (stall_mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= $urandom_range(0, 1);
                    2: i_m_tready <= ($urandom_range(0, 7) != 0);
                    default: i_m_tready <= rx_cycle[2];
                endcase
            end
        end
    end

    // Watchdog: no handshake on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_alloc_result res;
        t_handle       h1, h2;
        t_handle       pick_h;
        t_handle       live_list[$];
        t_handle       freed_list[$];
        t_op           op;
        logic [ID_W-1:0]  id;
        logic [GEN_W-1:0] gen;
        int            pick;
        int            k;

        sb = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Null handle and empty table
        send_item(OP_CHECK, '0, '0, res);
        send_item(OP_DESTROY, '0, 8'hFF, res);

        // Fresh ids, alive checks, high-water mark and range edges
        send_item(OP_CREATE, '0, '0, res);
        h1 = {res.handle_id, res.handle_gen};
        send_item(OP_CREATE, 11'h7FF, 8'hFF, res);
        h2 = {res.handle_id, res.handle_gen};
        send_item(OP_CHECK, h1.id, h1.gen, res);
        send_item(OP_CHECK, h1.id, 8'hFF, res);
        send_item(OP_CHECK, 11'd3, '0, res);
        send_item(OP_CHECK, ID_W'(MAX_SLOTS), '0, res);

        // Destroy, dead handle on destroy, reuse with bumped generation
        send_item(OP_DESTROY, h1.id, h1.gen, res);
        send_item(OP_DESTROY, h1.id, h1.gen, res);
        send_item(OP_CREATE, '0, '0, res);
        h1 = {res.handle_id, res.handle_gen};

        // LIFO order of the free stack
        send_item(OP_DESTROY, h2.id, h2.gen, res);
        send_item(OP_DESTROY, h1.id, h1.gen, res);
        send_item(OP_CREATE, '0, '0, res);
        h1 = {res.handle_id, res.handle_gen};
        send_item(OP_CREATE, '0, '0, res);
        h2 = {res.handle_id, res.handle_gen};

        // Freed handle that looks alive again, then live count floor
        send_item(OP_DESTROY, h1.id, h1.gen, res);
        send_item(OP_DESTROY, h1.id, h1.gen + 8'd1, res);
        send_item(OP_DESTROY, h2.id, h2.gen, res);
        send_item(OP_CLEAR, '0, '0, res);
        send_item(OP_CHECK, h2.id, h2.gen + 8'd1, res);

        // Generation wraps on one slot
        send_item(OP_CREATE, '0, '0, res);
        h1 = {res.handle_id, res.handle_gen};
        for (int i = 0; i < 256; i++) begin
            send_item(OP_DESTROY, h1.id, h1.gen, res);
            send_item(OP_CREATE, '0, '0, res);
            h1 = {res.handle_id, res.handle_gen};
        end
        send_item(OP_CHECK, h1.id, h1.gen, res);
        send_item(OP_CLEAR, '0, '0, res);

        // Random traffic, mostly on handles that are actually held
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 40)
                hold_requests <= hold_requests + 1;
            if (n == 100) begin
                i_s_tvalid <= 1'b0;
                while (sb.outstanding() != 0)
                    @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            id   = rand_id();
            gen  = rand_gen();
            if (pick < 30 || (pick < 70 && live_list.size() == 0)) begin
                op = OP_CREATE;
            end else if (pick < 55) begin
                k = $urandom_range(0, live_list.size() - 1);
                pick_h = live_list[k];
                live_list.delete(k);
                op  = OP_DESTROY;
                id  = pick_h.id;
                gen = pick_h.gen;
                freed_list.insert(freed_list.size(),
                                  t_handle'{pick_h.id, pick_h.gen + 8'd1});
                if (freed_list.size() > 16)
                    void'(freed_list.pop_front());
            end else if (pick < 70) begin
                pick_h = live_list[$urandom_range(0, live_list.size() - 1)];
                op  = OP_CHECK;
                id  = pick_h.id;
                gen = pick_h.gen;
            end else if (pick < 80 && freed_list.size() != 0) begin
                // stale handle, old or bumped generation
                pick_h = freed_list[$urandom_range(0, freed_list.size() - 1)];
                op  = $urandom_range(0, 1) ? OP_DESTROY : OP_CHECK;
                id  = pick_h.id;
                gen = $urandom_range(0, 1) ? pick_h.gen : pick_h.gen - 8'd1;
            end else if (pick < 98) begin
                op = t_op'($urandom_range(0, 2));
            end else begin
                op = OP_CLEAR;
                live_list.delete();
                freed_list.delete();
            end
            send_item(op, id, gen, res);
            if (op == OP_CREATE && res.status == ST_DONE)
                live_list.insert(live_list.size(),
                                 t_handle'{res.handle_id, res.handle_gen});
        end

        // Drain and report
        i_s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
